// ===== sv/ntfm_pkg.sv =====
// package for the nearest timestamp frame matcher
// transfer structs, queue entry type, request codes and controller states
// no dependencies
package ntfm_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned StaleW            = 5;
  localparam int unsigned TimeW             = 32;
  localparam int unsigned TagW              = 16;
  localparam int unsigned MaxDiffW          = 16;
  localparam logic [MaxDiffW-1:0] MaxDiffReset = 16'd100;

  // request and response codes
  localparam logic REQ_PUSH    = 1'b0;
  localparam logic REQ_LOOKUP  = 1'b1;
  localparam logic RESP_PUSH   = 1'b0;
  localparam logic RESP_LOOKUP = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [TimeW-1:0] frame_time;
    logic [TagW-1:0]  frame_tag;
  } in_item_t;

  typedef struct packed {
    logic              resp_kind;
    logic              push_accepted;
    logic              match_found;
    logic [TimeW-1:0]  match_time;
    logic [TagW-1:0]   match_tag;
    logic [StaleW-1:0] stale_dropped;
  } out_item_t;

  // one stored secondary frame
  typedef struct packed {
    logic [TimeW-1:0] ent_time;
    logic [TagW-1:0]  ent_tag;
  } entry_t;

  // per-cell control from the controller
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

endpackage

// ===== sv/ntfm_cell.sv =====
// one queue cell of the frame matcher: holds a single entry
// shifts in its upper neighbor on a pop, loads the pushed frame on a write
// depends on ntfm_pkg
module ntfm_cell
  import ntfm_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     nbr_in,
  input  entry_t     load_in,
  output entry_t     q
);

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      q_r <= nbr_in;
    end else if (ctrl.load) begin
      q_r <= load_in;
    end
  end

  assign q = q_r;

endmodule

// ===== sv/nearest_timestamp_frame_matcher_unit.sv =====
// top level of the nearest timestamp frame matcher
// row of ntfm_cell entries (cell 0 is the queue head) plus the lookup walker
// depends on ntfm_pkg and ntfm_cell
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_item_t  (push or lookup request)
//   out_     output     out_valid/out_stall out_item_t (one response per request)
//   cfg_     input      cfg_we             max_diff_ms, 16 bit
//
// a push writes its response straight into the output register
// a lookup walks the queue once it is taken: the walker looks at the head cell
// once per cycle, every pop shifts the whole cell row down by one, and the walk
// ends at the first entry that is not older or when the queue runs empty
// a new request is taken only when the walker is idle and the output register
// is empty, so a stalled response holds off the next request
// rst_n is synchronous: queue empty, max_diff_ms back to 100, no response
module nearest_timestamp_frame_matcher_unit
  import ntfm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [MaxDiffW-1:0] cfg_wdata
);

  localparam int unsigned FillW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IdxW  = $clog2(QUEUE_DEPTH);

  // controller registers
  state_t              state_r, state_nxt;
  logic [FillW-1:0]    fill_r, fill_nxt;
  logic [MaxDiffW-1:0] max_r;
  logic                out_valid_r, out_valid_nxt;
  logic                taken_r, taken_nxt;
  logic [StaleW-1:0]   stale_r, stale_nxt;

  // walk payload registers
  logic [TimeW-1:0]    time_r, time_nxt;
  logic [MaxDiffW-1:0] best_gap_r, best_gap_nxt;
  entry_t              cand_r, cand_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // cell row
  entry_t              cell_q [QUEUE_DEPTH];
  logic                pop;
  logic                push_wr;
  logic [IdxW-1:0]     wr_idx;
  entry_t              push_entry;

  // head compare
  entry_t              head;
  logic                older;
  logic [TimeW-1:0]    gap_old;
  logic [TimeW-1:0]    gap_new;
  logic                take_new;

  out_item_t           item;
  logic                out_load;

  assign head       = cell_q[0];
  assign wr_idx     = fill_r[IdxW-1:0];
  assign push_entry = '{ent_time: in_data.frame_time, ent_tag: in_data.frame_tag};

  assign older    = head.ent_time < time_r;
  assign gap_old  = time_r - head.ent_time;
  assign gap_new  = head.ent_time - time_r;
  assign take_new = gap_new < {{(TimeW-MaxDiffW){1'b0}}, best_gap_r};

  // row of cells, each shifting toward the head on a pop
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     nbr;
    assign ctrl = '{shift: pop, load: push_wr && (wr_idx == IdxW'(i))};
    if (i + 1 < QUEUE_DEPTH) begin : g_mid
      assign nbr = cell_q[i+1];
    end else begin : g_last
      assign nbr = cell_q[i];
    end
    ntfm_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .nbr_in  (nbr),
      .load_in (push_entry),
      .q       (cell_q[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      max_r       <= MaxDiffReset;
      out_valid_r <= 1'b0;
      taken_r     <= 1'b0;
      stale_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      taken_r     <= taken_nxt;
      stale_r     <= stale_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    time_r     <= time_nxt;
    best_gap_r <= best_gap_nxt;
    cand_r     <= cand_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    taken_nxt     = taken_r;
    stale_nxt     = stale_r;
    time_nxt      = time_r;
    best_gap_nxt  = best_gap_r;
    cand_nxt      = cand_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    pop           = 1'b0;
    push_wr       = 1'b0;
    out_load      = 1'b0;
    item          = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          if (in_data.req_type == REQ_PUSH) begin
            item.resp_kind = RESP_PUSH;
            out_load       = 1'b1;
            if (fill_r < FillW'(QUEUE_DEPTH)) begin
              push_wr            = 1'b1;
              fill_nxt           = fill_r + FillW'(1);
              item.push_accepted = 1'b1;
            end
          end else begin
            // start a walk: window opens at max_diff_ms
            time_nxt     = in_data.frame_time;
            best_gap_nxt = max_r;
            taken_nxt    = 1'b0;
            stale_nxt    = '0;
            state_nxt    = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        item.resp_kind     = RESP_LOOKUP;
        item.stale_dropped = stale_r;
        if (fill_r == '0) begin
          // queue ran dry: candidate counts only if strictly inside window
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (taken_r && (best_gap_r < max_r)) begin
            item.match_found = 1'b1;
            item.match_time  = cand_r.ent_time;
            item.match_tag   = cand_r.ent_tag;
          end
        end else if (older && (gap_old > {{(TimeW-MaxDiffW){1'b0}}, max_r})) begin
          // too old, discard
          pop      = 1'b1;
          fill_nxt = fill_r - FillW'(1);
          if (stale_r != '1) begin
            stale_nxt = stale_r + StaleW'(1);
          end
        end else if (older) begin
          // older but inside window, becomes the candidate
          pop          = 1'b1;
          fill_nxt     = fill_r - FillW'(1);
          cand_nxt     = head;
          best_gap_nxt = gap_old[MaxDiffW-1:0];
          taken_nxt    = 1'b1;
        end else begin
          // first entry that is not older ends the walk
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (take_new) begin
            pop              = 1'b1;
            fill_nxt         = fill_r - FillW'(1);
            item.match_found = 1'b1;
            item.match_time  = head.ent_time;
            item.match_tag   = head.ent_tag;
          end else if (taken_r) begin
            item.match_found = 1'b1;
            item.match_time  = cand_r.ent_time;
            item.match_tag   = cand_r.ent_tag;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = item;
    end
  end

  assign in_stall  = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
